// ----- design/mm_pkg.sv -----
// Shared types and codes for the matrix multiply engine.
// No dependencies; used by matrix_multiply_top.
package mm_pkg;

    localparam int DIM_W  = 4;   // configured dimension registers
    localparam int IDX_W  = 3;   // row and column indexes
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int PROD_W = 35;  // result width, wraps beyond this
    localparam int REG_W  = 2;   // register index within paddr

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd2;

    localparam logic [REG_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [REG_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [REG_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [REG_W-1:0] REG_B_COLS = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // Travels with each multiply-accumulate through the pipeline.
    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_all;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

// ----- design/mm_store.sv -----
// Element store with one write port and one registered read port.
// Per-entry valid bits clear at reset so unwritten entries read as zero.
module mm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int EW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [EW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [EW-1:0] o_rdata
);

    logic [EW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [EW-1:0]    r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ----- design/matrix_multiply_top.sv -----
// Integer matrix multiply engine: command port, APB configuration, sequencer and MAC.
// Depends on mm_pkg and mm_store.
//
// A load command (A or B) leaves busy low. A compute command with an empty or
// mismatched shape gives its single error result in the next cycle. A valid
// compute walks one multiply-accumulate per cycle through a single shared
// multiplier while busy is high, and gives its product elements row by row, each
// result once the last multiply-accumulate for that element has been summed. Each
// result shows on the result ports for exactly one cycle with o_result_valid high;
// the receiver cannot stall it, so it must take every result as it comes.
module matrix_multiply_top #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [mm_pkg::CMD_W-1:0]         i_cmd,
    input  logic [mm_pkg::IDX_W-1:0]         i_row_index,
    input  logic [mm_pkg::IDX_W-1:0]         i_col_index,
    input  logic signed [ELEM_WIDTH-1:0]     i_element,
    // result channel
    output logic                             o_result_valid,
    output logic [mm_pkg::STAT_W-1:0]        o_status,
    output logic [mm_pkg::IDX_W-1:0]         o_out_row,
    output logic [mm_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [mm_pkg::PROD_W-1:0] o_product,
    output logic                             o_last,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mm_pkg::REG_W+1:0]         paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = 2 * ELEM_WIDTH;
    localparam int XW    = (MW > mm_pkg::PROD_W) ? MW : mm_pkg::PROD_W;
    localparam logic [mm_pkg::DIM_W-1:0] MAX_D = mm_pkg::DIM_W'(MAX_DIM);
    localparam logic [mm_pkg::DIM_W-1:0] ONE_D = mm_pkg::DIM_W'(1);

    // configuration registers
    logic [mm_pkg::DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic                     w_cfg_wr;
    logic [mm_pkg::REG_W-1:0] w_reg_sel;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_sel = paddr[mm_pkg::REG_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= '0;
            r_a_cols <= '0;
            r_b_rows <= '0;
            r_b_cols <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                mm_pkg::REG_A_ROWS: r_a_rows <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_A_COLS: r_a_cols <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_B_ROWS: r_b_rows <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_B_COLS: r_b_cols <= pwdata[mm_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg_sel)
            mm_pkg::REG_A_ROWS: prdata = 32'(r_a_rows);
            mm_pkg::REG_A_COLS: prdata = 32'(r_a_cols);
            mm_pkg::REG_B_ROWS: prdata = 32'(r_b_rows);
            mm_pkg::REG_B_COLS: prdata = 32'(r_b_cols);
            default: prdata = '0;
        endcase
    end

    // effective dimensions, clamped to the store size
    logic [mm_pkg::DIM_W-1:0] w_ar, w_ac, w_br, w_bc;
    logic                     w_empty, w_mismatch;

    assign w_ar       = (r_a_rows > MAX_D) ? MAX_D : r_a_rows;
    assign w_ac       = (r_a_cols > MAX_D) ? MAX_D : r_a_cols;
    assign w_br       = (r_b_rows > MAX_D) ? MAX_D : r_b_rows;
    assign w_bc       = (r_b_cols > MAX_D) ? MAX_D : r_b_cols;
    assign w_empty    = (w_ar == '0) || (w_ac == '0) || (w_br == '0) || (w_bc == '0);
    assign w_mismatch = (w_ac != w_br);

    // command decode
    logic w_accept, w_compute, w_load_a, w_load_b;
    logic w_row_a_ok, w_col_a_ok, w_row_b_ok, w_col_b_ok;
    logic [AW-1:0] w_waddr;

    assign w_accept   = start && !busy;
    assign w_compute  = w_accept && (i_cmd == mm_pkg::CMD_COMPUTE);
    assign w_row_a_ok = {1'b0, i_row_index} < w_ar;
    assign w_col_a_ok = {1'b0, i_col_index} < w_ac;
    assign w_row_b_ok = {1'b0, i_row_index} < w_br;
    assign w_col_b_ok = {1'b0, i_col_index} < w_bc;
    assign w_load_a   = w_accept && (i_cmd == mm_pkg::CMD_LOAD_A) && w_row_a_ok && w_col_a_ok;
    assign w_load_b   = w_accept && (i_cmd == mm_pkg::CMD_LOAD_B) && w_row_b_ok && w_col_b_ok;
    assign w_waddr    = AW'(32'(i_row_index) * MAX_DIM + 32'(i_col_index));

    // sequencer
    mm_pkg::t_state r_state, n_state;
    logic [mm_pkg::DIM_W-1:0] r_ar, r_ac, r_bc;
    logic [mm_pkg::IDX_W-1:0] r_i, r_j, r_k;
    logic w_k_end, w_j_end, w_i_end, w_issue, w_start_run;

    assign w_start_run = w_compute && !w_empty && !w_mismatch;
    assign w_k_end     = ({1'b0, r_k} == (r_ac - ONE_D));
    assign w_j_end     = ({1'b0, r_j} == (r_bc - ONE_D));
    assign w_i_end     = ({1'b0, r_i} == (r_ar - ONE_D));

    // pipeline tags
    logic         r_t1_vld, r_t2_vld;
    mm_pkg::t_tag r_t1, r_t2;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mm_pkg::ST_IDLE: begin
                if (w_start_run) begin
                    n_state = mm_pkg::ST_ISSUE;
                end
            end
            mm_pkg::ST_ISSUE: begin
                if (w_k_end && w_j_end && w_i_end) begin
                    n_state = mm_pkg::ST_DRAIN;
                end
            end
            mm_pkg::ST_DRAIN: begin
                if (r_t2_vld && r_t2.last_all) begin
                    n_state = mm_pkg::ST_IDLE;
                end
            end
            default: n_state = mm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy    = (r_state != mm_pkg::ST_IDLE);
        w_issue = (r_state == mm_pkg::ST_ISSUE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // loop counters: k innermost, then column, then row
    always_ff @(posedge i_clk) begin
        if (w_start_run) begin
            r_ar <= w_ar;
            r_ac <= w_ac;
            r_bc <= w_bc;
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
        end else if (w_issue) begin
            if (w_k_end) begin
                r_k <= '0;
                if (w_j_end) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // stores
    logic [AW-1:0]         w_a_raddr, w_b_raddr;
    logic [ELEM_WIDTH-1:0] w_a_q, w_b_q;

    assign w_a_raddr = AW'(32'(r_i) * MAX_DIM + 32'(r_k));
    assign w_b_raddr = AW'(32'(r_k) * MAX_DIM + 32'(r_j));

    mm_store #(.DEPTH(DEPTH), .AW(AW), .EW(ELEM_WIDTH)) u_a_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_load_a),
        .i_waddr (w_waddr),
        .i_wdata ($unsigned(i_element)),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_q)
    );

    mm_store #(.DEPTH(DEPTH), .AW(AW), .EW(ELEM_WIDTH)) u_b_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_load_b),
        .i_waddr (w_waddr),
        .i_wdata ($unsigned(i_element)),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_q)
    );

    // MAC pipeline: read, multiply, accumulate
    logic signed [MW-1:0]             r_mul;
    logic signed [XW-1:0]             w_mul_ext;
    logic signed [mm_pkg::PROD_W-1:0] r_acc, w_acc_in, w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
        end else begin
            r_t1_vld <= w_issue;
            r_t2_vld <= r_t1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1.first    <= (r_k == '0);
        r_t1.last_k   <= w_k_end;
        r_t1.last_all <= w_k_end && w_j_end && w_i_end;
        r_t1.row      <= r_i;
        r_t1.col      <= r_j;
        r_t2          <= r_t1;
        r_mul         <= MW'($signed(w_a_q) * $signed(w_b_q));
    end

    assign w_mul_ext = XW'(r_mul);
    assign w_acc_in  = r_t2.first ? '0 : r_acc;
    assign w_sum     = w_acc_in + w_mul_ext[mm_pkg::PROD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_t2_vld) begin
            r_acc <= w_sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= (w_compute && (w_empty || w_mismatch))
                              || (r_t2_vld && r_t2.last_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_compute && (w_empty || w_mismatch)) begin
            o_status  <= w_empty ? mm_pkg::STAT_EMPTY : mm_pkg::STAT_MISMATCH;
            o_out_row <= '0;
            o_out_col <= '0;
            o_product <= '0;
            o_last    <= 1'b1;
        end else if (r_t2_vld && r_t2.last_k) begin
            o_status  <= mm_pkg::STAT_OK;
            o_out_row <= r_t2.row;
            o_out_col <= r_t2.col;
            o_product <= w_sum;
            o_last    <= r_t2.last_all;
        end
    end

endmodule
